@@ hw/rtl/wbps_pkg.sv @@
// Shared constants, register indexes and types for the wildcard byte pattern search.
`default_nettype none
package wbps_pkg;

    localparam int MAX_PATTERN  = 16;
    localparam int ADDRESS_BITS = 32;

    // pattern bytes actually compared; the registers hold 16 at most
    localparam int PAT_CAP   = (MAX_PATTERN < 16) ? MAX_PATTERN : 16;
    localparam int WIN_CELLS = PAT_CAP - 1;

    localparam int PAT_BYTES   = 16;
    localparam int LEN_W       = 5;
    localparam int COUNT_W     = 16;
    localparam int MASK_W      = 16;
    localparam int CFG_DATA_W  = 64;
    localparam int REG_INDEX_W = 3;

    localparam logic [REG_INDEX_W-1:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [REG_INDEX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
    localparam logic [REG_INDEX_W-1:0] REG_WILDCARD_MASK  = 3'd2;
    localparam logic [REG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
    localparam logic [REG_INDEX_W-1:0] REG_MATCH_NUMBER   = 3'd4;

    // per-beat control broadcast to every window cell
    typedef struct packed {
        logic shift;   // accepted beat moves the window
        logic clear;   // end of scan: empty the window
        logic gap;     // address break: older bytes no longer count
    } cell_ctrl_t;

endpackage
`default_nettype wire

@@ hw/rtl/wbps_scan_if.sv @@
// Input channel: one scanned memory byte per beat.
`default_nettype none
interface wbps_scan_if;
    logic                              valid;
    logic                              ready;
    logic [7:0]                        data_byte;
    logic [wbps_pkg::ADDRESS_BITS-1:0] byte_address;
    logic                              last_byte;

    modport source (output valid, output data_byte, output byte_address, output last_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input byte_address, input last_byte,
                    output ready);
endinterface
`default_nettype wire

@@ hw/rtl/wbps_result_if.sv @@
// Output channel: one search result per beat.
`default_nettype none
interface wbps_result_if;
    logic                              valid;
    logic                              ready;
    logic                              found;
    logic [wbps_pkg::ADDRESS_BITS-1:0] match_address;

    modport source (output valid, output found, output match_address, input ready);
    modport sink   (input valid, input found, input match_address, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/wbps_cell.sv @@
// One window cell: holds a past byte, passes it on, compares it with its pattern byte.
`default_nettype none
module wbps_cell (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire wbps_pkg::cell_ctrl_t ctrl,
    input  wire [7:0]                 byte_in,
    input  wire                       valid_in,
    input  wire [7:0]                 pat_byte,
    input  wire                       wild,
    input  wire                       in_use,
    output logic [7:0]                byte_q,
    output logic                      valid_q,
    output logic                      ok
);

    logic [7:0] byte_reg;
    logic       valid_reg;
    logic       valid_next;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_next = valid_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            byte_reg <= byte_in;
        end
    end

    // unused positions pass; used ones need a live byte that fits
    assign ok      = !in_use || (valid_reg && !ctrl.gap && (wild || (byte_reg == pat_byte)));
    assign byte_q  = byte_reg;
    assign valid_q = valid_reg;

endmodule
`default_nettype wire

@@ hw/rtl/wildcard_byte_pattern_search.sv @@
// Top level of the wildcard byte pattern search.
`default_nettype none
// Scans a stream of addressed bytes for a pattern of 1 to 16 bytes, any of which may be a
// wildcard, and reports the start address of the Nth match of a scan (overlaps count).
// The scan ends with a beat marked last_byte; a scan without the Nth match gives one
// not-found result. An address that is not the previous one plus one restarts the window
// but keeps the match count. After a found result, beats are swallowed up to and including
// the last_byte beat. Throughput is one byte per clock: the past bytes sit in a row of
// window cells that shift every accepted beat and compare all positions in parallel, so a
// match is decided in the cycle the byte is accepted and the result appears in the output
// register on the next cycle. The only stall is a result held in that register while the
// sink is not ready. Configuration is written through a plain write port (index 0..4:
// pattern_low, pattern_high, wildcard_mask, pattern_length, match_number) while idle; no
// reset sweep is needed, the block takes beats right after reset.
module wildcard_byte_pattern_search (
    input  wire                                    clk,
    input  wire                                    rst_n,
    wbps_scan_if.sink                              scan,
    wbps_result_if.source                          result,
    input  wire                                    write_en,
    input  wire [wbps_pkg::REG_INDEX_W-1:0]        write_index,
    input  wire [wbps_pkg::CFG_DATA_W-1:0]         write_data
);

    localparam int AW = wbps_pkg::ADDRESS_BITS;
    localparam int NC = wbps_pkg::WIN_CELLS;
    localparam int LW = wbps_pkg::LEN_W;
    localparam int CW = wbps_pkg::COUNT_W;

    // ---------------- configuration registers ----------------
    logic [7:0]                  pattern_reg [wbps_pkg::PAT_BYTES];
    logic [wbps_pkg::MASK_W-1:0] wildcard_reg;
    logic [LW-1:0]               length_reg;
    logic [CW-1:0]               match_number_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < wbps_pkg::PAT_BYTES; b++)
            begin
                pattern_reg[b] <= 8'd0;
            end
            wildcard_reg     <= '0;
            length_reg       <= LW'(1);
            match_number_reg <= CW'(1);
        end
        else if (write_en)
        begin
            unique case (write_index)
                wbps_pkg::REG_PATTERN_LOW:
                begin
                    for (int b = 0; b < 8; b++)
                    begin
                        pattern_reg[b] <= write_data[8*b +: 8];
                    end
                end
                wbps_pkg::REG_PATTERN_HIGH:
                begin
                    for (int b = 0; b < 8; b++)
                    begin
                        pattern_reg[b+8] <= write_data[8*b +: 8];
                    end
                end
                wbps_pkg::REG_WILDCARD_MASK:  wildcard_reg     <= write_data[wbps_pkg::MASK_W-1:0];
                wbps_pkg::REG_PATTERN_LENGTH: length_reg       <= write_data[LW-1:0];
                wbps_pkg::REG_MATCH_NUMBER:   match_number_reg <= write_data[CW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // length 0 acts as 1, beyond the cap acts as the cap
    logic [LW-1:0] len_used;

    always_comb
    begin
        if (length_reg == '0)
        begin
            len_used = LW'(1);
        end
        else if (length_reg > LW'(wbps_pkg::PAT_CAP))
        begin
            len_used = LW'(wbps_pkg::PAT_CAP);
        end
        else
        begin
            len_used = length_reg;
        end
    end

    // Position p (0 = incoming byte, p = k+1 = window cell k) lines up with
    // pattern byte len_used-1-p.
    logic [7:0] pos_pat  [wbps_pkg::PAT_CAP];
    logic       pos_wild [wbps_pkg::PAT_CAP];
    logic       pos_use  [wbps_pkg::PAT_CAP];

    always_comb
    begin
        logic [LW-1:0] j;
        for (int p = 0; p < wbps_pkg::PAT_CAP; p++)
        begin
            j           = LW'(len_used - LW'(1) - LW'(p));
            pos_use[p]  = LW'(p) < len_used;
            pos_pat[p]  = pattern_reg[j[3:0]];
            pos_wild[p] = wildcard_reg[j[3:0]];
        end
    end

    // ---------------- handshake ----------------
    logic          out_valid_reg;
    logic          out_found_reg;
    logic [AW-1:0] out_addr_reg;
    logic          accept;

    assign scan.ready = !out_valid_reg || result.ready;
    assign accept     = scan.valid && scan.ready;

    // ---------------- scan state ----------------
    logic [AW-1:0] prev_addr_reg;
    logic [CW-1:0] count_reg;
    logic          finished_reg;

    logic [AW-1:0] prev_addr_next;
    logic [CW-1:0] count_next;
    logic          finished_next;

    logic [7:0] cell_byte  [NC];
    logic       cell_valid [NC];
    logic       cell_ok    [NC];
    logic [7:0] link_byte  [NC];
    logic       link_valid [NC];

    wbps_pkg::cell_ctrl_t ctrl;

    logic          live;        // accepted beat that is scanned, not swallowed
    logic          gap;
    logic          hit;
    logic [CW-1:0] count_inc;
    logic          found_now;
    logic          emit;
    logic          emit_found;
    logic [AW-1:0] emit_addr;

    assign live = accept && !finished_reg;
    assign gap  = cell_valid[0] && (scan.byte_address != AW'(prev_addr_reg + AW'(1)));

    always_comb
    begin
        ctrl.shift = live;
        ctrl.gap   = gap;
        ctrl.clear = accept && scan.last_byte;
    end

    // window chain: new byte enters cell 0, older bytes drop one cell per beat
    always_comb
    begin
        link_byte[0]  = scan.data_byte;
        link_valid[0] = 1'b1;
        for (int k = 1; k < NC; k++)
        begin
            link_byte[k]  = cell_byte[k-1];
            link_valid[k] = cell_valid[k-1] && !gap;
        end
    end

    for (genvar k = 0; k < NC; k++)
    begin : g_cell
        wbps_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .byte_in  (link_byte[k]),
            .valid_in (link_valid[k]),
            .pat_byte (pos_pat[k+1]),
            .wild     (pos_wild[k+1]),
            .in_use   (pos_use[k+1]),
            .byte_q   (cell_byte[k]),
            .valid_q  (cell_valid[k]),
            .ok       (cell_ok[k])
        );
    end

    always_comb
    begin
        hit = pos_wild[0] || (scan.data_byte == pos_pat[0]);
        for (int k = 0; k < NC; k++)
        begin
            hit = hit && cell_ok[k];
        end
    end

    assign count_inc = (count_reg == '1) ? count_reg : CW'(count_reg + CW'(1));
    assign found_now = live && hit && (match_number_reg != '0) && (count_inc == match_number_reg);

    always_comb
    begin
        prev_addr_next = prev_addr_reg;
        count_next     = count_reg;
        finished_next  = finished_reg;
        emit           = 1'b0;
        emit_found     = 1'b0;
        emit_addr      = '0;
        if (live)
        begin
            prev_addr_next = scan.byte_address;
            if (hit)
            begin
                count_next = count_inc;
            end
            if (found_now)
            begin
                emit          = 1'b1;
                emit_found    = 1'b1;
                emit_addr     = AW'(scan.byte_address - AW'(len_used - LW'(1)));
                finished_next = 1'b1;
            end
            else if (scan.last_byte)
            begin
                emit = 1'b1;
            end
        end
        // end of scan resets the match state, found or not
        if (accept && scan.last_byte)
        begin
            count_next    = '0;
            finished_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_addr_reg <= '0;
            count_reg     <= '0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prev_addr_reg <= prev_addr_next;
            count_reg     <= count_next;
            finished_reg  <= finished_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_found_reg <= emit_found;
            out_addr_reg  <= emit_addr;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.found         = out_found_reg;
    assign result.match_address = out_addr_reg;

endmodule
`default_nettype wire

@@ hw/rtl/wbps_checker.sv @@
// Port-level checks on the wildcard byte pattern search, bound to the top level.
`default_nettype none
module wbps_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              scan_valid,
    input wire                              scan_ready,
    input wire                              result_valid,
    input wire                              result_ready,
    input wire                              result_found,
    input wire [wbps_pkg::ADDRESS_BITS-1:0] result_match_address
);

    // a held result keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_found) && $stable(result_match_address))
        else $error("result beat changed while stalled");

    // not-found beats carry a zero address
    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_found |-> result_match_address == '0)
        else $error("not-found result with nonzero address");

    // a new result beat follows an accepted input beat
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(scan_valid && scan_ready))
        else $error("result beat without an input beat");

    // only a pending result can stall the input side
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> scan_ready)
        else $error("input stalled with empty output register");

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .scan_valid           (scan.valid),
    .scan_ready           (scan.ready),
    .result_valid         (result.valid),
    .result_ready         (result.ready),
    .result_found         (result.found),
    .result_match_address (result.match_address)
);
`default_nettype wire

@@ tb/sv/wildcard_byte_pattern_search_tb.sv @@
// Testbench for wildcard_byte_pattern_search: directed and random scans checked beat by beat.
`default_nettype none
module wildcard_byte_pattern_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Percent chance that each side holds off.
    localparam int     IDLE_PCT      = 28;
    // The result is registered from the accepted beat; the extra settle time covers it.
    localparam int     SETTLE_CYCLES = 4;
    localparam int     RANDOM_PHASES = 12;
    localparam int     PHASE_BEATS   = 50;
    // Phase run with both sides always willing.
    localparam int     STEADY_PHASE  = 5;
    localparam int     REPORT_LIMIT  = 10;
    // Long count scan: every byte matches, the wanted match is the second to last byte.
    localparam int     COUNT_SCAN    = 160;
    localparam longint TIMEOUT_NS    = 2_000_000;

    typedef struct packed {
        logic [7:0]                        data;
        logic [wbps_pkg::ADDRESS_BITS-1:0] addr;
        logic                              last;
    } scan_beat_t;

    typedef struct packed {
        logic                              found;
        logic [wbps_pkg::ADDRESS_BITS-1:0] addr;
    } search_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                             write_en;
    logic [wbps_pkg::REG_INDEX_W-1:0] write_index;
    logic [wbps_pkg::CFG_DATA_W-1:0]  write_data;

    wbps_scan_if   scan_ch();
    wbps_result_if result_ch();

    wildcard_byte_pattern_search u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .scan        (scan_ch),
        .result      (result_ch),
        .write_en    (write_en),
        .write_index (write_index),
        .write_data  (write_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the register file, kept in step with every write.
    // ------------------------------------------------------------------
    logic [8*wbps_pkg::PAT_BYTES-1:0] cfg_pattern      = '0;
    logic [wbps_pkg::MASK_W-1:0]      cfg_wildcard     = '0;
    logic [wbps_pkg::LEN_W-1:0]       cfg_length       = 5'd1;
    logic [wbps_pkg::COUNT_W-1:0]     cfg_match_number = 16'd1;

    // ------------------------------------------------------------------
    // Search state mirrored from the block's point of view.
    // window_bytes[0] is the newest byte before the current one.
    // ------------------------------------------------------------------
    logic [7:0]                        window_bytes [0:wbps_pkg::MAX_PATTERN-1];
    int unsigned                       window_fill   = 0;
    logic [wbps_pkg::ADDRESS_BITS-1:0] last_address  = '0;
    logic [wbps_pkg::COUNT_W-1:0]      hits_in_scan  = '0;
    bit                                scan_settled  = 1'b0;   // Nth match already reported

    scan_beat_t     scan_bytes_todo [$];   // beats waiting for the driver
    search_result_t reports_due     [$];   // predicted results, oldest first
    int             beats_in_flight = 0;   // queued or on the bus, not yet accepted
    int             mismatch_count  = 0;
    bit             scan_taken      = 1'b0;
    bit             steady          = 1'b0;

    function automatic logic [7:0] pattern_byte(input int unsigned j);
        return cfg_pattern[8*j +: 8];
    endfunction

    // Length register 0 behaves as 1, anything past the cap as the cap.
    function automatic int unsigned used_pattern_length();
        if (cfg_length == 0)
            return 1;
        if (cfg_length > wbps_pkg::PAT_CAP)
            return wbps_pkg::PAT_CAP;
        return cfg_length;
    endfunction

    function automatic void clear_scan_state();
        for (int k = 0; k < wbps_pkg::MAX_PATTERN; k++)
            window_bytes[k] = 8'h00;
        window_fill  = 0;
        hits_in_scan = '0;
        scan_settled = 1'b0;
    endfunction

    // One accepted byte: update the mirrored search and queue any result it causes.
    function automatic void advance_search(input scan_beat_t b);
        int unsigned    len;
        int unsigned    j;
        bit             hit;
        logic [7:0]     cand;
        search_result_t r;

        // After the Nth match everything up to the scan's last beat is swallowed.
        if (scan_settled)
        begin
            if (b.last)
                clear_scan_state();
            return;
        end

        // Address break: older bytes no longer join a match, count is kept.
        if (window_fill > 0 && b.addr != last_address + 1'b1)
            window_fill = 0;

        len = used_pattern_length();
        hit = (window_fill + 1 >= len);
        for (int k = 0; k < len && hit; k++)
        begin
            j    = len - 1 - k;
            cand = (k == 0) ? b.data : window_bytes[k-1];
            if (!cfg_wildcard[j] && pattern_byte(j) != cand)
                hit = 1'b0;
        end

        for (int k = wbps_pkg::MAX_PATTERN - 1; k > 0; k--)
            window_bytes[k] = window_bytes[k-1];
        window_bytes[0] = b.data;
        if (window_fill < wbps_pkg::MAX_PATTERN - 1)
            window_fill++;
        last_address = b.addr;

        if (hit)
        begin
            if (hits_in_scan != '1)
                hits_in_scan++;
            // match_number 0 is never reached
            if (cfg_match_number != 0 && hits_in_scan == cfg_match_number)
            begin
                r.found = 1'b1;
                r.addr  = b.addr - (len - 1);   // wraps modulo the address width
                reports_due = {reports_due, r};
                if (b.last)
                    clear_scan_state();
                else
                    scan_settled = 1'b1;
                return;
            end
        end

        if (b.last)
        begin
            r.found = 1'b0;
            r.addr  = '0;
            reports_due = {reports_due, r};
            clear_scan_state();
        end
    endfunction

    task automatic note_mismatch(input string what, input search_result_t want,
                                 input search_result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s: expected found=%0b addr=%h, got found=%0b addr=%h",
                     $time, what, want.found, want.addr, got.found, got.addr);
    endtask

    // ------------------------------------------------------------------
    // Driver: new beat on the falling edge once the previous one was taken.
    // valid gets at most one nonblocking assignment per edge.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : driver
        scan_beat_t nb;
        if (!scan_ch.valid || scan_taken)
        begin
            if (scan_bytes_todo.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                nb = scan_bytes_todo.pop_front();
                scan_ch.valid        <= 1'b1;
                scan_ch.data_byte    <= nb.data;
                scan_ch.byte_address <= nb.addr;
                scan_ch.last_byte    <= nb.last;
            end
            else
            begin
                scan_ch.valid <= 1'b0;
            end
        end
        // Sink side stalls on its own random schedule.
        result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Monitor: both channels sampled on the rising edge. The result beat is
    // checked before the input beat of the same edge is predicted, since a
    // result is always registered after its byte.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        search_result_t got;
        search_result_t due;
        scan_beat_t     beat;
        if (rst_n)
        begin
            scan_taken <= scan_ch.valid && scan_ch.ready;
            if (result_ch.valid && result_ch.ready)
            begin
                got.found = result_ch.found;
                got.addr  = result_ch.match_address;
                if (reports_due.size() == 0)
                begin
                    note_mismatch("result with none pending", '0, got);
                end
                else
                begin
                    due = reports_due.pop_front();
                    if (got.found !== due.found)
                        note_mismatch("found flag differs", due, got);
                    else if (got.addr !== due.addr)
                        note_mismatch("match address differs", due, got);
                end
            end
            if (scan_ch.valid && scan_ch.ready)
            begin
                beat.data = scan_ch.data_byte;
                beat.addr = scan_ch.byte_address;
                beat.last = scan_ch.last_byte;
                advance_search(beat);
                beats_in_flight--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_beat(input logic [7:0] data,
                             input logic [wbps_pkg::ADDRESS_BITS-1:0] addr,
                             input logic last);
        scan_beat_t b;
        b.data = data;
        b.addr = addr;
        b.last = last;
        scan_bytes_todo = {scan_bytes_todo, b};
        beats_in_flight++;
    endtask

    // Block is idle: every beat taken, every result seen, plus settle time.
    task automatic wait_drained();
        while (beats_in_flight != 0 || reports_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Called on a falling edge; the write lands on the next rising edge.
    task automatic write_register(input logic [wbps_pkg::REG_INDEX_W-1:0] index,
                                  input logic [wbps_pkg::CFG_DATA_W-1:0] value);
        write_en    = 1'b1;
        write_index = index;
        write_data  = value;
        case (index)
            wbps_pkg::REG_PATTERN_LOW:    cfg_pattern[63:0]   = value;
            wbps_pkg::REG_PATTERN_HIGH:   cfg_pattern[127:64] = value;
            wbps_pkg::REG_WILDCARD_MASK:  cfg_wildcard        = value[wbps_pkg::MASK_W-1:0];
            wbps_pkg::REG_PATTERN_LENGTH: cfg_length          = value[wbps_pkg::LEN_W-1:0];
            wbps_pkg::REG_MATCH_NUMBER:   cfg_match_number    = value[wbps_pkg::COUNT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        write_en = 1'b0;
    endtask

    task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [wbps_pkg::MASK_W-1:0] mask,
                             input logic [wbps_pkg::LEN_W-1:0] len,
                             input logic [wbps_pkg::COUNT_W-1:0] nth);
        write_register(wbps_pkg::REG_PATTERN_LOW,    lo);
        write_register(wbps_pkg::REG_PATTERN_HIGH,   hi);
        write_register(wbps_pkg::REG_WILDCARD_MASK,  wbps_pkg::CFG_DATA_W'(mask));
        write_register(wbps_pkg::REG_PATTERN_LENGTH, wbps_pkg::CFG_DATA_W'(len));
        write_register(wbps_pkg::REG_MATCH_NUMBER,   wbps_pkg::CFG_DATA_W'(nth));
    endtask

    task automatic random_config();
        logic [127:0]                 pat;
        logic [wbps_pkg::MASK_W-1:0]  mask;
        logic [wbps_pkg::LEN_W-1:0]   len;
        logic [wbps_pkg::COUNT_W-1:0] nth;
        int                           r;
        bit                           narrow;
        // a small alphabet makes accidental and overlapping matches likely
        narrow = ($urandom_range(99) < 50);
        for (int j = 0; j < wbps_pkg::PAT_BYTES; j++)
        begin
            r = $urandom_range(3);
            if (narrow)
                pat[8*j +: 8] = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : (r == 2) ? 8'h41 : 8'h42;
            else
                pat[8*j +: 8] = 8'($urandom);
        end

        r = $urandom_range(99);
        if (r < 50)
            len = 5'($urandom_range(1, 4));
        else if (r < 70)
            len = 5'($urandom_range(5, 15));
        else if (r < 84)
            len = 5'd16;
        else if (r < 92)
            len = 5'($urandom_range(17, 31));   // past the cap: acts as 16
        else
            len = 5'd0;                         // acts as 1

        r = $urandom_range(99);
        if (r < 40)
            mask = '0;
        else if (r < 80)
        begin
            for (int j = 0; j < wbps_pkg::MASK_W; j++)
                mask[j] = ($urandom_range(99) < 20);
        end
        else if (r < 90)
            mask = '1;
        else
            mask = wbps_pkg::MASK_W'($urandom);

        r = $urandom_range(99);
        if (r < 55)
            nth = 16'd1;
        else if (r < 80)
            nth = 16'($urandom_range(2, 4));
        else if (r < 88)
            nth = 16'd0;                        // never reached
        else if (r < 95)
            nth = 16'($urandom_range(5, 30));
        else
            nth = '1;

        configure(pat[63:0], pat[127:64], mask, len, nth);
    endtask

    // Scans built mostly from pattern copies (wildcard slots random, some
    // copies damaged or cut off by the scan end) mixed with noise bytes.
    task automatic random_traffic(input int target);
        logic [7:0]                        content [$];
        logic [7:0]                        b;
        logic [wbps_pkg::ADDRESS_BITS-1:0] cur;
        int unsigned                       len;
        int                                sent;
        int                                scan_len;
        int                                pick;
        int                                spoil;
        len  = used_pattern_length();
        sent = 0;
        while (sent < target)
        begin
            cur = ($urandom_range(99) < 15)
                ? ('1 - wbps_pkg::ADDRESS_BITS'($urandom_range(0, 24)))
                : wbps_pkg::ADDRESS_BITS'($urandom);
            scan_len = ($urandom_range(99) < 15) ? $urandom_range(1, 3) : $urandom_range(4, 48);
            content.delete();
            while (content.size() < scan_len)
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                begin
                    spoil = (pick < 10) ? $urandom_range(0, len - 1) : -1;
                    for (int k = 0; k < len; k++)
                    begin
                        b = cfg_wildcard[k] ? 8'($urandom) : pattern_byte(k);
                        if (k == spoil)
                            b = b ^ (8'h01 << $urandom_range(0, 7));
                        content = {content, b};
                    end
                end
                else if (pick < 80)
                    content = {content, pattern_byte($urandom_range(0, len - 1))};
                else
                    content = {content, 8'($urandom)};
            end
            for (int n = 0; n < scan_len; n++)
            begin
                // occasional address break: repeated address or a jump
                pick = $urandom_range(99);
                if (n != 0 && pick < 2)
                    cur = cur - 1'b1;
                else if (n != 0 && pick < 5)
                    cur = wbps_pkg::ADDRESS_BITS'($urandom);
                push_beat(content[n], cur, n == scan_len - 1);
                cur = cur + 1'b1;
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int k = 0; k < wbps_pkg::MAX_PATTERN; k++)
            window_bytes[k] = 8'h00;
        rst_n                = 1'b0;
        write_en             = 1'b0;
        write_index          = '0;
        write_data           = '0;
        scan_ch.valid        = 1'b0;
        scan_ch.data_byte    = '0;
        scan_ch.byte_address = '0;
        scan_ch.last_byte    = 1'b0;
        result_ch.ready      = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: one-byte pattern 00. Find, swallow to end of scan,
        // a find on the last beat at the top address, then a plain miss.
        push_beat(8'hFF, 32'h0000_0000, 1'b0);
        push_beat(8'h00, 32'h0000_0001, 1'b0);
        push_beat(8'h12, 32'h0000_0002, 1'b0);
        push_beat(8'h55, 32'h0000_0003, 1'b1);
        push_beat(8'h00, 32'hFFFF_FFFF, 1'b1);
        push_beat(8'h01, 32'h0000_0000, 1'b1);
        wait_drained();

        // "ABA", second match: overlaps the first and its start wraps below zero.
        configure(64'h0000_0000_0041_4241, 64'h0, 16'h0000, 5'd3, 16'd2);
        push_beat(8'h41, 32'hFFFF_FFFC, 1'b0);
        push_beat(8'h42, 32'hFFFF_FFFD, 1'b0);
        push_beat(8'h41, 32'hFFFF_FFFE, 1'b0);
        push_beat(8'h42, 32'hFFFF_FFFF, 1'b0);
        push_beat(8'h41, 32'h0000_0000, 1'b1);
        push_beat(8'h41, 32'h0000_0001, 1'b1);
        wait_drained();

        // Address gap splits a would-be match; a fresh one starts after the gap.
        configure(64'h0000_0000_0041_4241, 64'h0, 16'h0000, 5'd3, 16'd1);
        push_beat(8'h41, 32'h0000_0010, 1'b0);
        push_beat(8'h42, 32'h0000_0011, 1'b0);
        push_beat(8'h41, 32'h0000_0020, 1'b0);
        push_beat(8'h42, 32'h0000_0021, 1'b0);
        push_beat(8'h41, 32'h0000_0022, 1'b0);
        push_beat(8'h77, 32'h0000_0023, 1'b1);
        wait_drained();

        // Length 0 acts as 1; match number 0 is never reached.
        configure(64'h0000_0000_0000_007E, 64'h0, 16'h0000, 5'd0, 16'd0);
        push_beat(8'h7E, 32'h0000_0100, 1'b0);
        push_beat(8'h7E, 32'h0000_0101, 1'b1);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            steady = (p == STEADY_PHASE);
            if (p == 1)
                configure('1, '0, 16'h8001, 5'd16, 16'd1);
            else if (p == 2)
                configure('0, '1, '1, 5'd31, '1);
            else
                random_config();
            random_traffic(PHASE_BEATS);
            wait_drained();
        end
        steady = 1'b0;

        // Every byte matches; the wanted match is the second to last byte,
        // the final byte is swallowed and closes the scan.
        configure('0, '0, '1, 5'd1, wbps_pkg::COUNT_W'(COUNT_SCAN - 1));
        for (int n = 0; n < COUNT_SCAN; n++)
            push_beat(8'($urandom), 32'hFFFF_8000 + n, n == COUNT_SCAN - 1);
        wait_drained();
        // a short run of random traffic to see the count came back to zero
        random_config();
        random_traffic(40);
        wait_drained();

        if (reports_due.size() != 0)
        begin
            mismatch_count += reports_due.size();
            $display("%0d predicted results never arrived", reports_due.size());
        end
        if (mismatch_count == 0)
            $display("wildcard_byte_pattern_search verification clean");
        else
            $display("wildcard_byte_pattern_search verification failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("wildcard_byte_pattern_search verification failed");
        $finish;
    end

endmodule
`default_nettype wire

@@ wildcard_byte_pattern_search.f @@
hw/rtl/wbps_pkg.sv
hw/rtl/wbps_scan_if.sv
hw/rtl/wbps_result_if.sv
hw/rtl/wbps_cell.sv
hw/rtl/wildcard_byte_pattern_search.sv
hw/rtl/wbps_checker.sv
tb/sv/wildcard_byte_pattern_search_tb.sv
